FILE: src/ps_pkg.sv
// Shared types, constants and lookup functions for the percentile selector.
package ps_pkg;

  localparam int unsigned MAX_VALUES = 256;
  localparam int unsigned GROUP_SIZE = 4;
  localparam int unsigned PCT_COUNT  = 11;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(MAX_VALUES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_VALUES);
  localparam int unsigned RANK_W = 4;
  localparam int unsigned GPOS_W = $clog2(GROUP_SIZE);
  localparam int unsigned PERM_W = 10;

  // floor(x / 1000) as (x * RECIP) >> DIV_SHIFT, exact for x below 2**PROD_W
  localparam longint unsigned DIVISOR   = 1000;
  localparam int unsigned     PROD_W    = CNT_W + PERM_W;
  localparam int unsigned     DIV_SHIFT = PROD_W + PERM_W;
  localparam longint unsigned RECIP     = ((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned     RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned     MUL_W     = PROD_W + RECIP_W;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } ps_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_CMP,
    S_INS_LAST,
    S_OUT_MUL,
    S_OUT_DIV,
    S_OUT_RD,
    S_OUT_LOAD,
    S_EMPTY
  } ps_state_e;

  typedef struct packed {
    logic accept;
    logic ins_start;
    logic ins_step;
    logic ins_last;
    logic out_mul;
    logic out_div;
    logic out_rd;
    logic out_load;
    logic out_empty;
    logic clear;
  } ps_cmd_t;

  typedef struct packed {
    logic ins_pending;
    logic full;
    logic cnt_zero;
    logic gt;
    logic slot_one;
    logic last;
    logic out_free;
    logic k_last;
  } ps_stat_t;

  function automatic logic [PERM_W-1:0] perm_f(input logic [RANK_W-1:0] k);
    logic [PERM_W-1:0] p;
    case (k)
      4'd0:    p = 10'd1;
      4'd1:    p = 10'd5;
      4'd2:    p = 10'd10;
      4'd3:    p = 10'd50;
      4'd4:    p = 10'd100;
      4'd5:    p = 10'd500;
      4'd6:    p = 10'd900;
      4'd7:    p = 10'd950;
      4'd8:    p = 10'd990;
      4'd9:    p = 10'd995;
      4'd10:   p = 10'd999;
      default: p = 10'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: src/ps_ctrl.sv
// Controller state machine: sequences intake, insertion and result readout.
module ps_ctrl
  import ps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ps_stat_t stat_i,
  output ps_cmd_t  cmd_o
);

  ps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_INS_CHECK;
      end
      S_INS_CHECK: begin
        if (!stat_i.ins_pending) begin
          if (!stat_i.last)        state_d = S_IDLE;
          else if (stat_i.cnt_zero) state_d = S_EMPTY;
          else                     state_d = S_OUT_MUL;
        end else if (!stat_i.full && !stat_i.cnt_zero) begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (!stat_i.gt)           state_d = S_INS_CHECK;
        else if (stat_i.slot_one) state_d = S_INS_LAST;
      end
      S_INS_LAST: state_d = S_INS_CHECK;
      S_OUT_MUL:  state_d = S_OUT_DIV;
      S_OUT_DIV:  state_d = S_OUT_RD;
      S_OUT_RD:   state_d = S_OUT_LOAD;
      S_OUT_LOAD: begin
        if (stat_i.out_free) state_d = stat_i.k_last ? S_IDLE : S_OUT_MUL;
      end
      S_EMPTY: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_INS_CHECK: cmd_o.ins_start = stat_i.ins_pending;
      S_INS_CMP:   cmd_o.ins_step  = 1'b1;
      S_INS_LAST:  cmd_o.ins_last  = 1'b1;
      S_OUT_MUL:   cmd_o.out_mul   = 1'b1;
      S_OUT_DIV:   cmd_o.out_div   = 1'b1;
      S_OUT_RD:    cmd_o.out_rd    = 1'b1;
      S_OUT_LOAD: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.clear    = stat_i.out_free && stat_i.k_last;
      end
      S_EMPTY: begin
        cmd_o.out_empty = stat_i.out_free;
        cmd_o.clear     = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: src/ps_datapath.sv
// Datapath: group intake, sorted store with shift insertion, index math, result register.
module ps_datapath
  import ps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ps_cmd_t                  cmd_i,
  output ps_stat_t                 stat_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic signed [DATA_W-1:0] residual_value_i,
  input  logic                     final_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RANK_W-1:0]        percentile_rank_o,
  output logic signed [DATA_W-1:0] quantile_value_o,
  output logic [1:0]               status_o,
  output logic                     run_end_o
);

  localparam logic [GPOS_W-1:0] GPOS_LAST = GPOS_W'(GROUP_SIZE - 1);

  // control state
  logic              comp_sel_q;
  logic [GPOS_W-1:0] grp_pos_q;
  logic [1:0]        pend_q;
  logic [CNT_W-1:0]  count_q;
  logic              ovf_q;
  logic              last_q;
  logic [1:0]        ins_left_q;
  logic              ins_sel_q;
  logic [RANK_W-1:0] k_q;
  logic              out_valid_q;

  // payload
  logic signed [DATA_W-1:0] held_q [2];
  logic signed [DATA_W-1:0] ins_val_q;
  logic [ADDR_W-1:0]        slot_q;
  logic [PROD_W-1:0]        prod_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic [RANK_W-1:0]        rank_q;
  logic signed [DATA_W-1:0] qval_q;
  logic [1:0]               stat_q;
  logic                     end_q;

  logic signed [DATA_W-1:0] mem [MAX_VALUES];

  // intake
  logic [GPOS_W-1:0] first_kept;
  logic              keep;
  logic              pend_inc;
  logic [1:0]        pend_after;
  logic              grp_end;

  assign first_kept = GPOS_W'({comp_sel_q, 1'b0});
  assign keep       = (grp_pos_q == first_kept) || (grp_pos_q == (first_kept | GPOS_W'(1)));
  assign pend_inc   = keep && (pend_q != 2'd2);
  assign pend_after = pend_q + {1'b0, pend_inc};
  assign grp_end    = (grp_pos_q == GPOS_LAST);

  // status
  logic full, cnt_zero, gt, slot_one, out_free;
  logic signed [DATA_W-1:0] held_sel;

  assign held_sel = held_q[ins_sel_q];
  assign full     = (count_q == CNT_W'(MAX_VALUES));
  assign cnt_zero = (count_q == '0);
  assign gt       = (rdata_q > ins_val_q);
  assign slot_one = (slot_q == ADDR_W'(1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o             = '0;
    stat_o.ins_pending = (ins_left_q != 2'd0);
    stat_o.full        = full;
    stat_o.cnt_zero    = cnt_zero;
    stat_o.gt          = gt;
    stat_o.slot_one    = slot_one;
    stat_o.last        = last_q;
    stat_o.out_free    = out_free;
    stat_o.k_last      = (k_q == RANK_W'(PCT_COUNT - 1));
  end

  // store port control
  logic                     we, re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     cnt_inc;

  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = slot_q;
    raddr   = idx_q;
    wdata   = ins_val_q;
    cnt_inc = 1'b0;
    if (cmd_i.ins_start && !full) begin
      if (cnt_zero) begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = held_sel;
        cnt_inc = 1'b1;
      end else begin
        re    = 1'b1;
        raddr = count_q[ADDR_W-1:0] - ADDR_W'(1);
      end
    end
    if (cmd_i.ins_step) begin
      we = 1'b1;
      if (gt) begin
        // shift the larger entry up one slot and keep walking down
        wdata = rdata_q;
        if (!slot_one) begin
          re    = 1'b1;
          raddr = slot_q - ADDR_W'(2);
        end
      end else begin
        cnt_inc = 1'b1;
      end
    end
    if (cmd_i.ins_last) begin
      we      = 1'b1;
      waddr   = '0;
      cnt_inc = 1'b1;
    end
    if (cmd_i.out_rd) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // index math: idx = floor(permille * count / 1000), clamped below count
  logic [PROD_W-1:0] prod_d;
  logic [MUL_W-1:0]  quot_full;
  logic [CNT_W-1:0]  quot;
  logic [ADDR_W-1:0] idx_d;

  assign prod_d    = PROD_W'(perm_f(k_q)) * PROD_W'(count_q);
  assign quot_full = MUL_W'(prod_q) * MUL_W'(RECIP_W'(RECIP));
  assign quot      = quot_full[DIV_SHIFT +: CNT_W];

  always_comb begin
    logic [CNT_W-1:0] top;
    top   = count_q - CNT_W'(1);
    idx_d = (quot >= count_q) ? top[ADDR_W-1:0] : quot[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_sel_q  <= 1'b0;
      grp_pos_q   <= '0;
      pend_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      ins_left_q  <= '0;
      ins_sel_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) comp_sel_q <= cfg_wdata_i;

      if (cmd_i.accept) begin
        last_q <= final_item_i;
        if (grp_end) begin
          ins_left_q <= pend_after;
          ins_sel_q  <= 1'b0;
          pend_q     <= '0;
          grp_pos_q  <= '0;
        end else begin
          ins_left_q <= '0;
          pend_q     <= pend_after;
          grp_pos_q  <= grp_pos_q + GPOS_W'(1);
        end
      end

      if (cmd_i.ins_start) begin
        ins_left_q <= ins_left_q - 2'd1;
        ins_sel_q  <= ~ins_sel_q;
        if (full) ovf_q <= 1'b1;
      end

      if (cnt_inc) count_q <= count_q + CNT_W'(1);

      if (cmd_i.out_load) k_q <= k_q + RANK_W'(1);

      if (cmd_i.out_load || cmd_i.out_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.clear) begin
        count_q   <= '0;
        grp_pos_q <= '0;
        pend_q    <= '0;
        ovf_q     <= 1'b0;
        k_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pend_inc) held_q[pend_q[0]] <= residual_value_i;
    if (cmd_i.ins_start) begin
      ins_val_q <= held_sel;
      slot_q    <= count_q[ADDR_W-1:0];
    end
    if (cmd_i.ins_step && gt) slot_q <= slot_q - ADDR_W'(1);
    if (cmd_i.out_mul) prod_q <= prod_d;
    if (cmd_i.out_div) idx_q  <= idx_d;
    if (cmd_i.out_load) begin
      rank_q <= k_q;
      qval_q <= rdata_q;
      stat_q <= ovf_q ? STAT_OVERFLOW : STAT_OK;
      end_q  <= (k_q == RANK_W'(PCT_COUNT - 1));
    end else if (cmd_i.out_empty) begin
      rank_q <= '0;
      qval_q <= '0;
      stat_q <= STAT_EMPTY;
      end_q  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign percentile_rank_o = rank_q;
  assign quantile_value_o  = qval_q;
  assign status_o          = stat_q;
  assign run_end_o         = end_q;

endmodule

FILE: src/percentile_selector_core.sv
// Top level of the percentile selector: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o) carries residual samples in groups of four;
// the pair picked by cfg_wdata_i (written with cfg_we_i while idle) is kept from each
// complete group and placed into a 256-entry sorted store. A sample flagged final
// ends the run: eleven transactions leave on the output channel (out_valid_o /
// out_ready_i), ranks 0..10, run_end_o on the last; an empty run gives one
// transaction with status 2.
// Sequence: a sample that closes no group only passes the insert check. A group close
// adds, per kept value, a direct write when the store is empty, an overflow mark when
// full, else a read of the top entry and a compare-and-shift step per stored entry
// greater than it; the shift walk uses separate store read and write ports. Each
// result then goes through multiply, scale, store read and output register load.
// A result waits in the output register while the receiver stalls; readout pauses
// until it is taken, and a new sample is accepted while the last result still waits.
// Reset clears the run counters and the select register; the store needs no clearing
// pass since only written entries are ever read.
module percentile_selector_core
  import ps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] residual_value_i,
  input  logic                     final_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RANK_W-1:0]        percentile_rank_o,
  output logic signed [DATA_W-1:0] quantile_value_o,
  output logic [1:0]               status_o,
  output logic                     run_end_o
);

  ps_cmd_t  cmd;
  ps_stat_t stat;

  ps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ps_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .residual_value_i  (residual_value_i),
    .final_item_i      (final_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .percentile_rank_o (percentile_rank_o),
    .quantile_value_o  (quantile_value_o),
    .status_o          (status_o),
    .run_end_o         (run_end_o)
  );

endmodule

FILE: bench/quantile_checker.sv
// Checker for the percentile selector: predicts result transactions and compares them.
`timescale 1ns / 100ps

module quantile_checker
  import ps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [DATA_W-1:0] residual_value_i,
  input  logic                     final_item_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [RANK_W-1:0]        percentile_rank_i,
  input  logic signed [DATA_W-1:0] quantile_value_i,
  input  logic [1:0]               status_i,
  input  logic                     run_end_i,
  output int unsigned              error_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  localparam int unsigned PERMILLE_SCALE = 1000;
  // rank k sits at bits [k*PERM_W +: PERM_W]
  localparam logic [PCT_COUNT*PERM_W-1:0] PERMILLE = {
    10'd999, 10'd995, 10'd990, 10'd950, 10'd900, 10'd500,
    10'd100, 10'd50,  10'd10,  10'd5,   10'd1
  };

  typedef struct packed {
    logic [RANK_W-1:0]        rank;
    logic signed [DATA_W-1:0] value;
    ps_status_e               status;
    logic                     run_end;
  } pct_result_t;

  logic signed [DATA_W-1:0] sorted_vals[$];
  logic signed [DATA_W-1:0] held_vals[2];
  int unsigned              group_pos;
  int unsigned              held_cnt;
  logic                     overflow_seen;
  logic                     select_hi;
  pct_result_t              expected_results[$];
  pct_result_t              oldest;
  int unsigned              error_total = 0;
  int unsigned              checked_total = 0;
  int unsigned              pending_total = 0;

  assign error_count_o = error_total;
  assign pending_o     = pending_total;
  assign checked_o     = checked_total;

  function automatic void restart_data_set();
    sorted_vals.delete();
    group_pos     = 0;
    held_cnt      = 0;
    overflow_seen = 1'b0;
  endfunction

  // Advance the group/store state by one sample; on a final sample queue the percentiles.
  function automatic void absorb_residual(input logic signed [DATA_W-1:0] value,
                                          input logic last);
    pct_result_t res;
    int unsigned first_pos;
    int unsigned n;
    int unsigned idx;
    int unsigned slot;
    first_pos = select_hi ? 2 : 0;
    if ((group_pos == first_pos || group_pos == first_pos + 1) && held_cnt < 2) begin
      held_vals[held_cnt] = value;
      held_cnt++;
    end
    if (group_pos == GROUP_SIZE - 1) begin
      for (int k = 0; k < held_cnt; k++) begin
        if (sorted_vals.size() >= MAX_VALUES) begin
          overflow_seen = 1'b1;
        end else begin
          // equal values land after the ones already stored
          slot = 0;
          while (slot < sorted_vals.size() && sorted_vals[slot] <= held_vals[k]) slot++;
          sorted_vals.insert(slot, held_vals[k]);
        end
      end
      held_cnt  = 0;
      group_pos = 0;
    end else begin
      group_pos++;
    end
    if (last) begin
      n = sorted_vals.size();
      if (n == 0) begin
        res.rank    = '0;
        res.value   = '0;
        res.status  = STAT_EMPTY;
        res.run_end = 1'b1;
        expected_results = {expected_results, res};
      end else begin
        for (int k = 0; k < PCT_COUNT; k++) begin
          idx = (PERMILLE[k*PERM_W +: PERM_W] * n) / PERMILLE_SCALE;
          if (idx >= n) idx = n - 1;
          res.rank    = RANK_W'(k);
          res.value   = sorted_vals[idx];
          res.status  = overflow_seen ? STAT_OVERFLOW : STAT_OK;
          res.run_end = (k == PCT_COUNT - 1);
          expected_results = {expected_results, res};
        end
      end
      restart_data_set();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_data_set();
      select_hi = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) select_hi = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: rank %0d, value %0d",
                 percentile_rank_i, quantile_value_i);
          error_total++;
        end else begin
          oldest = expected_results.pop_front();
          checked_total++;
          if (percentile_rank_i !== oldest.rank) begin
            $error("percentile_rank mismatch: expected %0d, actual %0d",
                   oldest.rank, percentile_rank_i);
            error_total++;
          end
          if (quantile_value_i !== oldest.value) begin
            $error("quantile_value mismatch (rank %0d): expected %0d, actual %0d",
                   oldest.rank, oldest.value, quantile_value_i);
            error_total++;
          end
          if (status_i !== oldest.status) begin
            $error("status mismatch (rank %0d): expected %0d, actual %0d",
                   oldest.rank, oldest.status, status_i);
            error_total++;
          end
          if (run_end_i !== oldest.run_end) begin
            $error("run_end mismatch (rank %0d): expected %0d, actual %0d",
                   oldest.rank, oldest.run_end, run_end_i);
            error_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_residual(residual_value_i, final_item_i);
    end
    pending_total = expected_results.size();
  end

endmodule

FILE: bench/tb_percentile_selector_core.sv
// Testbench top for percentile_selector_core: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module tb_percentile_selector_core;
  import ps_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 600;
  localparam int unsigned RANDOM_SAMPLES  = 340;

  typedef enum int unsigned {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] residual_value_i;
  logic                     final_item_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [RANK_W-1:0]        percentile_rank_o;
  logic signed [DATA_W-1:0] quantile_value_o;
  logic [1:0]               status_o;
  logic                     run_end_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned select_writes = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 4;

  percentile_selector_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .residual_value_i  (residual_value_i),
    .final_item_i      (final_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .percentile_rank_o (percentile_rank_o),
    .quantile_value_o  (quantile_value_o),
    .status_o          (status_o),
    .run_end_o         (run_end_o)
  );

  quantile_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .residual_value_i  (residual_value_i),
    .final_item_i      (final_item_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .percentile_rank_i (percentile_rank_o),
    .quantile_value_i  (quantile_value_o),
    .status_i          (status_o),
    .run_end_i         (run_end_o),
    .error_count_o     (error_count),
    .pending_o         (pending_count),
    .checked_o         (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("percentile_selector_core test failed");
      $finish;
    end
  end

  // Receiver: a stall mode is picked at random and held for a random span
  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned left;
    int unsigned phase;
    out_ready_i = 1'b0;
    mode  = RX_OPEN;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(32, 200);
      end
      left--;
      phase++;
      case (mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_BUSY:   out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ((phase % 7) < 3);
      endcase
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_residual();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = int'($urandom_range(0, 16)) - 8;              // many duplicates
      1: v = int'($urandom_range(0, 128 * 65536)) - 64 * 65536;
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = 32'sh0000_0000;
          default: v = 32'shFFFF_FFFF;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  // unless a gap was taken.
  task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic last);
    int unsigned gap;
    in_valid_i       <= 1'b1;
    residual_value_i <= value;
    final_item_i     <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
    if (last) sets_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_select(input logic sel);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    select_writes++;
  endtask

  // noisy sets may carry a final flag on any sample
  task automatic send_set(input int unsigned n, input bit noisy);
    logic last;
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1) || (noisy && $urandom_range(0, 7) == 0);
      send_sample(rand_residual(), last);
    end
  endtask

  initial begin
    int unsigned base;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    in_valid_i       = 1'b0;
    residual_value_i = '0;
    final_item_i     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, pair 0/1 from reset: empty set on a lone final sample
    send_sample(32'sh0001_0000, 1'b1);
    // one group, extremes kept
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0005, 1'b0);
    send_sample(32'sh0000_0006, 1'b1);
    // full group then a partial one that must be dropped
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(32'shFFFF_FFFF, 1'b0);
    send_sample(32'sh1234_5678, 1'b0);
    send_sample(32'sh8765_4321, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    // partial group only: empty
    send_sample(32'sh0000_0001, 1'b0);
    send_sample(32'sh0000_0002, 1'b0);
    send_sample(32'sh0000_0003, 1'b1);

    write_select(1'b1);
    send_sample(32'sh0000_0011, 1'b0);
    send_sample(32'sh0000_0022, 1'b0);
    send_sample(32'shFFFF_0000, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    // only unkept positions seen: empty
    send_sample(32'sh0000_0044, 1'b0);
    send_sample(32'sh0000_0055, 1'b1);

    write_select(1'b0);

    base = samples_sent;
    while (samples_sent - base < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 3) == 0) write_select(1'($urandom_range(0, 1)));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0:       send_set($urandom_range(1, 3), 1'b0);
        1:       send_set($urandom_range(4, 40), 1'b1);
        2, 3:    send_set(4 * $urandom_range(1, 12) + $urandom_range(1, 3), 1'b0);
        default: send_set(4 * $urandom_range(1, 12), 1'b0);
      endcase
    end

    settle();
    $display("Checked %0d percentile results from %0d samples in %0d data sets.",
             checked_count, samples_sent, sets_sent);
    $display("Covered both pairs (%0d select writes), empty and partial sets, stalls.",
             select_writes);
    if (error_count == 0 && pending_count == 0) begin
      $display("percentile_selector_core test passed");
    end else begin
      $display("percentile_selector_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ps_pkg.sv
src/ps_ctrl.sv
src/ps_datapath.sv
src/percentile_selector_core.sv
bench/quantile_checker.sv
bench/tb_percentile_selector_core.sv
